[sv/ptl_pkg.sv]
package ptl_pkg;

	localparam int GLYPH_COUNT = 94;
	localparam int FIRST_CODE  = 33;
	localparam int COORD_BITS  = 16;

	localparam int GIDX_BITS = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int ADD_BITS  = 9;
	localparam int CNT_BITS  = $clog2(COORD_BITS);

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;

	localparam logic [2:0] REG_LETTER = 3'd0;
	localparam logic [2:0] REG_WORD   = 3'd1;
	localparam logic [2:0] REG_LINE   = 3'd2;
	localparam logic [2:0] REG_TAB    = 3'd3;
	localparam logic [2:0] REG_START  = 3'd4;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
		input logic [ADD_BITS-1:0] b);
		logic [COORD_BITS:0] sum;
		sum = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
		if (sum[COORD_BITS]) begin
			return '1;
		end
		return sum[COORD_BITS-1:0];
	endfunction

	function automatic logic [GIDX_BITS-1:0] glyph_of(input logic [7:0] code);
		logic [9:0] c;
		logic [9:0] q;
		c = 10'(code);
		q = 10'(CHAR_QMARK);
		if (c >= 10'(FIRST_CODE) && c < 10'(FIRST_CODE + GLYPH_COUNT)) begin
			return GIDX_BITS'(c - 10'(FIRST_CODE));
		end
		if (q >= 10'(FIRST_CODE) && q < 10'(FIRST_CODE + GLYPH_COUNT)) begin
			return GIDX_BITS'(q - 10'(FIRST_CODE));
		end
		return '0;
	endfunction

endpackage

[sv/ptl_if.sv]
interface ptl_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic       first_of_text;
	logic [7:0] char_code;
	logic [6:0] width_slot;
	logic [7:0] width_value;

	modport source (output valid, kind, first_of_text, char_code, width_slot, width_value,
		input ready);
	modport sink (input valid, kind, first_of_text, char_code, width_slot, width_value,
		output ready);
endinterface

interface ptl_out_if;
	logic                             valid;
	logic                             ready;
	logic [ptl_pkg::COORD_BITS-1:0]  glyph_x;
	logic [ptl_pkg::COORD_BITS-1:0]  glyph_y;
	logic [ptl_pkg::GIDX_BITS-1:0]   glyph_index;

	modport source (output valid, glyph_x, glyph_y, glyph_index, input ready);
	modport sink (input valid, glyph_x, glyph_y, glyph_index, output ready);
endinterface

[sv/ptl_div.sv]
module ptl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ptl_pkg::COORD_BITS-1:0] dividend,
	input  logic [7:0]                      divisor,
	output ptl_pkg::div_stat_t              stat,
	output logic [7:0]                      remainder
);

	localparam logic [ptl_pkg::CNT_BITS-1:0] LAST = ptl_pkg::CNT_BITS'(ptl_pkg::COORD_BITS - 1);

	logic                            busy_q;
	logic                            done_q;
	logic [ptl_pkg::CNT_BITS-1:0]   cnt_q;
	logic [8:0]                      rem_q;
	logic [ptl_pkg::COORD_BITS-1:0] num_q;
	logic [7:0]                      dvs_q;
	logic [8:0]                      trial;
	logic [8:0]                      rem_next;

	// one quotient bit a cycle, restoring
	always_comb begin
		trial = {rem_q[7:0], num_q[ptl_pkg::COORD_BITS-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = trial - {1'b0, dvs_q};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[ptl_pkg::COORD_BITS-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q[7:0];

endmodule

[sv/proportional_text_layout_top.sv]
// channel    dir  payload                                                  accepted
// in_item    in   kind, first_of_text, char_code, width_slot, width_value  valid & ready
// out_item   out  glyph_x, glyph_y, glyph_index                            valid & ready
// cfg        in   cfg_we, cfg_index, cfg_data                              cfg_we
//
// width load, space, newline: taken in the idle state; placed glyph: table read, place, advance
// tab with a non-zero stop: start, the bit-serial remainder unit (16 steps), then update
// no clearing pass after reset; the width table is undefined until loaded
// a finished result waits in the output register while the next item is taken;
// a glyph placement holds until that register is free
module proportional_text_layout_top (
	input  logic             clk,
	input  logic             arst_n,
	ptl_in_if.sink           in_item,
	ptl_out_if.source        out_item,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PLACE = 4'b0010,
		ST_ADV   = 4'b0100,
		ST_DIV   = 4'b1000
	} state_t;

	localparam int CB = ptl_pkg::COORD_BITS;
	localparam int GB = ptl_pkg::GIDX_BITS;

	state_t           state_q;
	logic [7:0]       letter_q;
	logic [7:0]       word_q;
	logic [7:0]       line_q;
	logic [7:0]       tab_q;
	logic [15:0]      start_row_q;
	logic [CB-1:0]    pen_x_q;
	logic [CB-1:0]    pen_y_q;
	logic [GB-1:0]    gidx_q;
	logic [7:0]       width_q;
	logic [7:0]       rd_q;
	logic             out_valid_q;
	logic [CB-1:0]    out_x_q;
	logic [CB-1:0]    out_y_q;
	logic [GB-1:0]    out_idx_q;

	logic [7:0]       width_mem [ptl_pkg::GLYPH_COUNT];

	logic             accept;
	logic             is_load;
	logic [CB-1:0]    px0;
	logic [CB-1:0]    py0;
	logic [GB-1:0]    gidx;
	logic             div_start;
	ptl_pkg::div_stat_t div_stat;
	logic [7:0]       div_rem;
	logic             out_free;
	logic [7:0]       gap;
	logic [CB-1:0]    centre_x;
	logic [CB-1:0]    tab_x;

	assign in_item.ready = (state_q == ST_IDLE);
	assign accept        = in_item.valid && in_item.ready;
	assign is_load       = (in_item.kind == ptl_pkg::KIND_LOAD);
	assign px0           = in_item.first_of_text ? '0 : pen_x_q;
	assign py0           = in_item.first_of_text ? CB'(start_row_q) : pen_y_q;
	assign gidx          = ptl_pkg::glyph_of(in_item.char_code);
	assign div_start     = accept && !is_load && (in_item.char_code == ptl_pkg::CHAR_TAB)
		&& (tab_q != 8'd0);
	assign out_free      = !out_valid_q || out_item.ready;
	assign gap           = (pen_x_q != '0) ? letter_q : 8'd0;
	assign centre_x      = ptl_pkg::sat_add(pen_x_q,
		ptl_pkg::ADD_BITS'(gap) + ptl_pkg::ADD_BITS'(rd_q[7:1]));
	assign tab_x         = ptl_pkg::sat_add(pen_x_q - CB'(div_rem), ptl_pkg::ADD_BITS'(tab_q));

	ptl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (px0),
		.divisor   (tab_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	// width table
	always_ff @(posedge clk) begin
		if (accept && is_load && (9'(in_item.width_slot) < 9'(ptl_pkg::GLYPH_COUNT))) begin
			width_mem[in_item.width_slot[GB-1:0]] <= in_item.width_value;
		end
		if (accept && !is_load) begin
			rd_q <= width_mem[gidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q    <= 8'd1;
			word_q      <= 8'd6;
			line_q      <= 8'd25;
			tab_q       <= 8'd28;
			start_row_q <= 16'd175;
		end else if (cfg_we) begin
			case (cfg_index)
				ptl_pkg::REG_LETTER: letter_q    <= cfg_data[7:0];
				ptl_pkg::REG_WORD:   word_q      <= cfg_data[7:0];
				ptl_pkg::REG_LINE:   line_q      <= cfg_data[7:0];
				ptl_pkg::REG_TAB:    tab_q       <= cfg_data[7:0];
				ptl_pkg::REG_START:  start_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pen_x_q     <= '0;
			pen_y_q     <= CB'(175);
			out_valid_q <= 1'b0;
		end else begin
			if (out_item.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_load) begin
						pen_x_q <= px0;
						pen_y_q <= py0;
						if (in_item.char_code == ptl_pkg::CHAR_SPACE) begin
							pen_x_q <= ptl_pkg::sat_add(px0, ptl_pkg::ADD_BITS'(word_q));
						end else if (in_item.char_code == ptl_pkg::CHAR_NL) begin
							pen_x_q <= '0;
							pen_y_q <= ptl_pkg::sat_add(py0, ptl_pkg::ADD_BITS'(line_q));
						end else if (in_item.char_code == ptl_pkg::CHAR_TAB) begin
							if (tab_q != 8'd0) begin
								state_q <= ST_DIV;
							end
						end else begin
							state_q <= ST_PLACE;
						end
					end
				end
				ST_PLACE: begin
					if (out_free) begin
						pen_x_q     <= centre_x;
						out_valid_q <= 1'b1;
						state_q     <= ST_ADV;
					end
				end
				ST_ADV: begin
					pen_x_q <= ptl_pkg::sat_add(pen_x_q,
						ptl_pkg::ADD_BITS'(width_q[7:1]) + ptl_pkg::ADD_BITS'(width_q[0]));
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						pen_x_q <= tab_x;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_load) begin
			gidx_q <= gidx;
		end
		if (state_q == ST_PLACE && out_free) begin
			out_x_q   <= centre_x;
			out_y_q   <= pen_y_q;
			out_idx_q <= gidx_q;
			width_q   <= rd_q;
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.glyph_x     = out_x_q;
	assign out_item.glyph_y     = out_y_q;
	assign out_item.glyph_index = out_idx_q;

endmodule

[sv/ptl_chk.sv]
module ptl_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            in_kind,
	input logic [7:0]                      in_code,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ptl_pkg::COORD_BITS-1:0] out_x,
	input logic [ptl_pkg::GIDX_BITS-1:0]  out_idx
);

	logic in_acc;
	logic no_result;

	assign in_acc    = in_valid && in_ready;
	assign no_result = (in_kind == ptl_pkg::KIND_LOAD) || (in_code == ptl_pkg::CHAR_SPACE)
		|| (in_code == ptl_pkg::CHAR_NL) || (in_code == ptl_pkg::CHAR_TAB);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_idx))
		else $error("result item dropped or changed while stalled");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && no_result && !out_valid |=> !out_valid)
		else $error("result item appeared for an item that places no glyph");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_idx) < ptl_pkg::GLYPH_COUNT))
		else $error("glyph index out of range");

	a_glyph_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !no_result && !out_valid |=> !in_ready ##1 out_valid)
		else $error("placed glyph did not give a result item");

endmodule

bind proportional_text_layout_top ptl_chk u_ptl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.in_kind   (in_item.kind),
	.in_code   (in_item.char_code),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.out_x     (out_item.glyph_x),
	.out_idx   (out_item.glyph_index)
);

[dv/proportional_text_layout_top_tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
	logic [ptl_pkg::COORD_BITS-1:0] glyph_x;
	logic [ptl_pkg::COORD_BITS-1:0] glyph_y;
	logic [ptl_pkg::GIDX_BITS-1:0]  glyph_index;
} placed_glyph_t;

class layout_scoreboard;
	logic [7:0]                     letter_gap;
	logic [7:0]                     word_gap;
	logic [7:0]                     line_gap;
	logic [7:0]                     tab_stop;
	logic [15:0]                    start_row;
	logic [ptl_pkg::COORD_BITS-1:0] pen_x;
	logic [ptl_pkg::COORD_BITS-1:0] pen_y;
	logic [7:0]                     glyph_width [ptl_pkg::GLYPH_COUNT];
	placed_glyph_t                  placed_q [$];
	int                             mismatches;

	function new();
		letter_gap = 8'd1;
		word_gap   = 8'd6;
		line_gap   = 8'd25;
		tab_stop   = 8'd28;
		start_row  = 16'd175;
		pen_x      = '0;
		pen_y      = ptl_pkg::COORD_BITS'(175);
		mismatches = 0;
		foreach (glyph_width[i]) glyph_width[i] = 8'd0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			ptl_pkg::REG_LETTER: letter_gap = data[7:0];
			ptl_pkg::REG_WORD:   word_gap   = data[7:0];
			ptl_pkg::REG_LINE:   line_gap   = data[7:0];
			ptl_pkg::REG_TAB:    tab_stop   = data[7:0];
			ptl_pkg::REG_START:  start_row  = data;
			default: ;
		endcase
	endfunction

	function logic [ptl_pkg::COORD_BITS-1:0] clamp_add(logic [ptl_pkg::COORD_BITS-1:0] a,
		longint unsigned b);
		longint unsigned top;
		longint unsigned s;
		top = (64'd1 << ptl_pkg::COORD_BITS) - 1;
		s = longint'(a) + b;
		return (s > top) ? ptl_pkg::COORD_BITS'(top) : ptl_pkg::COORD_BITS'(s);
	endfunction

	function logic [ptl_pkg::GIDX_BITS-1:0] glyph_slot(logic [7:0] code);
		int c;
		int q;
		c = code;
		q = ptl_pkg::CHAR_QMARK;
		if (c >= ptl_pkg::FIRST_CODE && c < ptl_pkg::FIRST_CODE + ptl_pkg::GLYPH_COUNT)
			return ptl_pkg::GIDX_BITS'(c - ptl_pkg::FIRST_CODE);
		if (q >= ptl_pkg::FIRST_CODE && q < ptl_pkg::FIRST_CODE + ptl_pkg::GLYPH_COUNT)
			return ptl_pkg::GIDX_BITS'(q - ptl_pkg::FIRST_CODE);
		return '0;
	endfunction

	function void note_item(logic kind, logic first, logic [7:0] code, logic [6:0] slot,
		logic [7:0] wval);
		placed_glyph_t                 g;
		logic [ptl_pkg::GIDX_BITS-1:0] gi;
		longint unsigned               w;
		longint unsigned               gap;
		longint unsigned               stops;
		longint unsigned               top;
		if (kind == ptl_pkg::KIND_LOAD) begin
			if (slot < ptl_pkg::GLYPH_COUNT) glyph_width[slot] = wval;
			return;
		end
		if (first) begin
			pen_x = '0;
			pen_y = ptl_pkg::COORD_BITS'(start_row);
		end
		case (code)
			ptl_pkg::CHAR_SPACE: pen_x = clamp_add(pen_x, word_gap);
			ptl_pkg::CHAR_NL: begin
				pen_x = '0;
				pen_y = clamp_add(pen_y, line_gap);
			end
			ptl_pkg::CHAR_TAB: begin
				if (tab_stop != 0) begin
					top = (64'd1 << ptl_pkg::COORD_BITS) - 1;
					stops = (longint'(pen_x) / tab_stop + 1) * tab_stop;
					pen_x = (stops > top) ? ptl_pkg::COORD_BITS'(top)
						: ptl_pkg::COORD_BITS'(stops);
				end
			end
			default: begin
				gi = glyph_slot(code);
				w = glyph_width[gi];
				gap = (pen_x != 0) ? letter_gap : 0;
				pen_x = clamp_add(pen_x, gap + (w >> 1));
				g.glyph_x = pen_x;
				g.glyph_y = pen_y;
				g.glyph_index = gi;
				placed_q.push_back(g);
				pen_x = clamp_add(pen_x, (w + 1) >> 1);
			end
		endcase
	endfunction

	task report(string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task check_result(placed_glyph_t got);
		placed_glyph_t want;
		if (placed_q.size() == 0) begin
			report($sformatf("unexpected glyph x %0d y %0d index %0d",
				got.glyph_x, got.glyph_y, got.glyph_index));
			return;
		end
		want = placed_q.pop_front();
		if (got.glyph_x !== want.glyph_x)
			report($sformatf("glyph_x got %0d, expected %0d", got.glyph_x, want.glyph_x));
		if (got.glyph_y !== want.glyph_y)
			report($sformatf("glyph_y got %0d, expected %0d", got.glyph_y, want.glyph_y));
		if (got.glyph_index !== want.glyph_index)
			report($sformatf("glyph_index got %0d, expected %0d",
				got.glyph_index, want.glyph_index));
	endtask

	function int pending();
		return placed_q.size();
	endfunction
endclass

module proportional_text_layout_top_tb;

	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	ptl_in_if  in_ch ();
	ptl_out_if out_ch ();

	layout_scoreboard sb;
	int               send_idle_pct;
	int               recv_idle_pct;
	bit               width_loaded [ptl_pkg::GLYPH_COUNT];

	proportional_text_layout_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_ch),
		.out_item  (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result('{out_ch.glyph_x, out_ch.glyph_y, out_ch.glyph_index});
	end

	task automatic send_item(logic kind, logic first, logic [7:0] code, logic [6:0] slot,
		logic [7:0] wval);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.kind          = kind;
		in_ch.first_of_text = first;
		in_ch.char_code     = code;
		in_ch.width_slot    = slot;
		in_ch.width_value   = wval;
		in_ch.valid         = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(kind, first, code, slot, wval);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_width();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_load(logic [6:0] slot, logic [7:0] wval);
		if (slot < ptl_pkg::GLYPH_COUNT) width_loaded[slot] = 1'b1;
		send_item(ptl_pkg::KIND_LOAD, 1'($urandom_range(1)), 8'($urandom_range(255)), slot,
			wval);
	endtask

	task automatic send_char(logic first, logic [7:0] code);
		logic [ptl_pkg::GIDX_BITS-1:0] g;
		if (code != ptl_pkg::CHAR_SPACE && code != ptl_pkg::CHAR_NL
			&& code != ptl_pkg::CHAR_TAB) begin
			g = sb.glyph_slot(code);
			if (!width_loaded[g]) send_load(7'(g), pick_width());
		end
		send_item(ptl_pkg::KIND_CHAR, first, code, 7'($urandom_range(127)),
			8'($urandom_range(255)));
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_layout(logic [7:0] letter, logic [7:0] word, logic [7:0] line,
		logic [7:0] tab, logic [15:0] row);
		logic [15:0] vals [5];
		logic [2:0]  idx [5];
		vals = '{16'(letter), 16'(word), 16'(line), 16'(tab), row};
		idx  = '{ptl_pkg::REG_LETTER, ptl_pkg::REG_WORD, ptl_pkg::REG_LINE, ptl_pkg::REG_TAB,
			ptl_pkg::REG_START};
		for (int i = 0; i < 5; i++) begin
			cfg_we    = 1'b1;
			cfg_index = idx[i];
			cfg_data  = vals[i];
			sb.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	task automatic random_items(int count, bit long_line);
		int          r;
		logic        first;
		logic [7:0]  code;
		logic [6:0]  slot;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < (long_line ? 3 : 10)) begin
				slot = ($urandom_range(99) < 85) ? 7'($urandom_range(ptl_pkg::GLYPH_COUNT - 1))
					: 7'($urandom_range(127, ptl_pkg::GLYPH_COUNT));
				send_load(slot, pick_width());
			end else begin
				first = long_line ? 1'b0 : ($urandom_range(39) == 0);
				r = $urandom_range(99);
				if (r < 62)
					code = 8'($urandom_range(ptl_pkg::FIRST_CODE + ptl_pkg::GLYPH_COUNT - 1,
						ptl_pkg::FIRST_CODE));
				else if (r < 74)
					code = ptl_pkg::CHAR_SPACE;
				else if (r < 80)
					code = long_line ? ptl_pkg::CHAR_SPACE : ptl_pkg::CHAR_NL;
				else if (r < 87)
					code = ptl_pkg::CHAR_TAB;
				else
					code = 8'($urandom_range(255));
				if (long_line && code == ptl_pkg::CHAR_NL) code = ptl_pkg::CHAR_QMARK;
				send_char(first, code);
			end
		end
	endtask

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = ptl_pkg::REG_LETTER;
		cfg_data            = '0;
		in_ch.valid         = 1'b0;
		in_ch.kind          = ptl_pkg::KIND_CHAR;
		in_ch.first_of_text = 1'b0;
		in_ch.char_code     = '0;
		in_ch.width_slot    = '0;
		in_ch.width_value   = '0;
		send_idle_pct       = 12;
		recv_idle_pct       = 63;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings, table edges and substitutes
		send_load(7'd0, 8'd0);
		send_load(7'(ptl_pkg::GLYPH_COUNT - 1), 8'd255);
		send_load(7'(ptl_pkg::CHAR_QMARK - ptl_pkg::FIRST_CODE), 8'd7);
		send_load(7'd127, 8'hAA);
		send_load(7'(ptl_pkg::GLYPH_COUNT), 8'h55);
		send_load(7'("A" - ptl_pkg::FIRST_CODE), 8'd13);
		send_char(1'b1, "!");
		send_char(1'b0, "~");
		send_char(1'b0, "A");
		send_char(1'b0, ptl_pkg::CHAR_SPACE);
		send_char(1'b0, "A");
		send_char(1'b0, ptl_pkg::CHAR_TAB);
		send_char(1'b0, ptl_pkg::CHAR_QMARK);
		send_char(1'b0, 8'h00);
		send_char(1'b0, 8'h7F);
		send_char(1'b0, 8'hFF);
		send_char(1'b0, 8'h0D);
		send_char(1'b0, ptl_pkg::CHAR_NL);
		send_char(1'b0, "A");
		send_char(1'b1, ptl_pkg::CHAR_TAB);
		send_char(1'b1, ptl_pkg::CHAR_NL);
		send_char(1'b0, 8'h80);
		send_char(1'b1, "~");
		settle();
		random_items(170, 1'b0);
		settle();

		program_layout(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		random_items(200, 1'b0);
		settle();

		send_idle_pct = 63;
		recv_idle_pct = 12;
		program_layout(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
		random_items(320, 1'b1);
		settle();

		program_layout(8'd17, 8'd3, 8'd255, 8'd1, 16'd65500);
		random_items(200, 1'b0);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_layout(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 16'($urandom_range(65535)));
		random_items(200, 1'b0);
		settle();

		program_layout(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 16'($urandom_range(65535)));
		random_items(110, 1'b0);
		settle();

		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
